// ===== rtl/iba_pkg.sv =====
// Shared types and constants of the ID bitmap allocator.
`default_nettype none
package iba_pkg;

  localparam int NUM_IDS        = 1024;
  localparam int MAP_WORDS      = 16;
  localparam int FIRST_VALID_ID = 1;
  localparam int WORD_BITS      = 64;

  localparam int ID_W   = 10;
  localparam int CNT_W  = ID_W + 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int WORD_W = ID_W - BIT_W;
  localparam int CFG_W  = 11;

  localparam int CAP_RAW  = MAP_WORDS * WORD_BITS;
  localparam int CAPACITY = (NUM_IDS < CAP_RAW) ? NUM_IDS : CAP_RAW;

  localparam logic [WORD_BITS-1:0] RESET_WORD0 =
    (WORD_BITS'(1) << FIRST_VALID_ID) - WORD_BITS'(1);

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_CLAIM   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic CFG_RESERVED = 1'b0;
  localparam logic CFG_IDS      = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFREE  = 3'd1,
    ST_BUSY    = 3'd2,
    ST_INVALID = 3'd3,
    ST_NOTUSED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]      action;
    logic            system_range;
    logic [ID_W-1:0] id_in;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] id_out;
  } rsp_t;

  // Result of one pass of the word search unit.
  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     pos;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] range;
  } hit_t;

endpackage
`default_nettype wire

// ===== rtl/iba_map.sv =====
// Used-bit store: one 64-bit word per row, reset with the low IDs taken.
`default_nettype none
module iba_map (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [iba_pkg::WORD_W-1:0]          rd_addr_i,
  output logic      [iba_pkg::WORD_BITS-1:0]       rd_data_o,
  input  wire logic                                we_i,
  input  wire logic [iba_pkg::WORD_W-1:0]          wr_addr_i,
  input  wire logic [iba_pkg::WORD_BITS-1:0]       wr_data_i
);

  logic [iba_pkg::WORD_BITS-1:0] words_q [iba_pkg::MAP_WORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iba_pkg::MAP_WORDS; i++) begin
        words_q[i] <= (i == 0) ? iba_pkg::RESET_WORD0 : '0;
      end
    end else if (we_i) begin
      words_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = words_q[rd_addr_i];

endmodule
`default_nettype wire

// ===== rtl/iba_word_unit.sv =====
// Shared search unit: finds the lowest free bit of one word inside an ID range.
`default_nettype none
module iba_word_unit (
  input  wire logic [iba_pkg::WORD_BITS-1:0] word_i,
  input  wire logic [iba_pkg::WORD_W-1:0]    word_idx_i,
  input  wire logic [iba_pkg::CNT_W-1:0]     lo_i,
  input  wire logic [iba_pkg::CNT_W-1:0]     hi_i,
  output iba_pkg::hit_t                      hit_o
);

  localparam logic [iba_pkg::WORD_BITS-1:0] ONES = '1;

  logic [iba_pkg::CNT_W-1:0]     hi_m1;
  logic [iba_pkg::WORD_BITS-1:0] lo_mask;
  logic [iba_pkg::WORD_BITS-1:0] hi_mask;
  logic [iba_pkg::WORD_BITS-1:0] free;
  logic [iba_pkg::WORD_BITS-1:0] onehot;
  logic [iba_pkg::BIT_W-1:0]     pos;

  always_comb begin
    hi_m1   = hi_i - iba_pkg::CNT_W'(1);
    lo_mask = (word_idx_i == lo_i[iba_pkg::ID_W-1:iba_pkg::BIT_W]) ?
              (ONES << lo_i[iba_pkg::BIT_W-1:0]) : ONES;
    // The last word of the range keeps bits up to and including hi - 1.
    hi_mask = (word_idx_i == hi_m1[iba_pkg::ID_W-1:iba_pkg::BIT_W]) ?
              (ONES >> (iba_pkg::BIT_W'(iba_pkg::WORD_BITS - 1) -
                        hi_m1[iba_pkg::BIT_W-1:0])) : ONES;
    free    = ~word_i & lo_mask & hi_mask;
    onehot  = free & (~free + iba_pkg::WORD_BITS'(1));
    pos     = '0;
    for (int j = 0; j < iba_pkg::WORD_BITS; j++) begin
      if (onehot[j]) begin
        pos = pos | iba_pkg::BIT_W'(j);
      end
    end
    hit_o.found  = |free;
    hit_o.pos    = pos;
    hit_o.onehot = onehot;
    hit_o.range  = lo_mask & hi_mask;
  end

endmodule
`default_nettype wire

// ===== rtl/id_bitmap_allocator_unit.sv =====
// Top level: request sequencer and configuration registers of the ID allocator.
// Claim and release take one pass of the word unit, in S_SCAN, before done_o rises.
// Allocate scans one 64-bit map word per cycle through the shared word unit;
// busy stays high for the whole scan, and done_o rises once it ends.
// Rejected requests answer in the cycle after start, and a new start is taken then.
// Reset is immediate: low IDs below the first valid ID are taken, all others free.
`default_nettype none
module id_bitmap_allocator_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire iba_pkg::req_t              req_i,
  output logic                            done_o,
  output iba_pkg::rsp_t                   rsp_o,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [iba_pkg::CFG_W-1:0]  cfg_data_i
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                     state_q, state_d;
  logic [iba_pkg::CNT_W-1:0]  reserved_q;
  logic [iba_pkg::CNT_W-1:0]  ids_q;
  logic [1:0]                 op_q, op_d;
  logic [iba_pkg::ID_W-1:0]   id_q, id_d;
  logic [iba_pkg::CNT_W-1:0]  lo_q, lo_d;
  logic [iba_pkg::CNT_W-1:0]  hi_q, hi_d;
  logic [iba_pkg::WORD_W-1:0] word_q, word_d;
  logic [iba_pkg::WORD_W-1:0] last_q, last_d;
  logic                       done_q, done_d;
  iba_pkg::rsp_t              rsp_q, rsp_d;

  logic [iba_pkg::CNT_W-1:0]     n_c;
  logic [iba_pkg::CNT_W-1:0]     alo_c;
  logic [iba_pkg::CNT_W-1:0]     ahi_c;
  logic [iba_pkg::CNT_W-1:0]     id_ext;
  logic [iba_pkg::CNT_W-1:0]     ahi_m1;
  logic [iba_pkg::WORD_BITS-1:0] rd_data;
  logic                          map_we;
  logic [iba_pkg::WORD_BITS-1:0] map_wdata;
  iba_pkg::hit_t                 hit;
  logic                          accept;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      ids_q      <= iba_pkg::CNT_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        iba_pkg::CFG_RESERVED: reserved_q <= cfg_data_i;
        iba_pkg::CFG_IDS:      ids_q      <= cfg_data_i;
        default:               ;
      endcase
    end
  end

  iba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (word_q),
    .rd_data_o (rd_data),
    .we_i      (map_we),
    .wr_addr_i (word_q),
    .wr_data_i (map_wdata)
  );

  iba_word_unit u_word (
    .word_i     (rd_data),
    .word_idx_i (word_q),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .hit_o      (hit)
  );

  always_comb begin
    n_c    = (ids_q > iba_pkg::CNT_W'(iba_pkg::CAPACITY)) ?
             iba_pkg::CNT_W'(iba_pkg::CAPACITY) : ids_q;
    alo_c  = req_i.system_range ? iba_pkg::CNT_W'(iba_pkg::FIRST_VALID_ID) : reserved_q;
    ahi_c  = req_i.system_range ? reserved_q : n_c;
    ahi_m1 = ahi_c - iba_pkg::CNT_W'(1);
    id_ext = {1'b0, req_i.id_in};

    state_d = state_q;
    op_d    = op_q;
    id_d    = id_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    word_d  = word_q;
    last_d  = last_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    map_we  = 1'b0;
    map_wdata = rd_data | hit.onehot;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = req_i.action;
          id_d = req_i.id_in;
          // Claim and release search a one-ID range in the word of that ID.
          lo_d   = id_ext;
          hi_d   = id_ext + iba_pkg::CNT_W'(1);
          word_d = req_i.id_in[iba_pkg::ID_W-1:iba_pkg::BIT_W];
          last_d = req_i.id_in[iba_pkg::ID_W-1:iba_pkg::BIT_W];
          rsp_d  = '{status: iba_pkg::ST_INVALID, id_out: '0};
          case (req_i.action)
            iba_pkg::ACT_ALLOC: begin
              if (ahi_c > n_c || alo_c >= ahi_c) begin
                rsp_d.status = iba_pkg::ST_NOFREE;
                done_d       = 1'b1;
              end else begin
                lo_d    = alo_c;
                hi_d    = ahi_c;
                word_d  = alo_c[iba_pkg::ID_W-1:iba_pkg::BIT_W];
                last_d  = ahi_m1[iba_pkg::ID_W-1:iba_pkg::BIT_W];
                state_d = S_SCAN;
              end
            end
            iba_pkg::ACT_CLAIM: begin
              if ((req_i.system_range && id_ext >= reserved_q) || id_ext >= n_c) begin
                done_d = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            iba_pkg::ACT_RELEASE: begin
              if (id_ext >= n_c ||
                  id_ext < iba_pkg::CNT_W'(iba_pkg::FIRST_VALID_ID)) begin
                done_d = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        if (op_q == iba_pkg::ACT_RELEASE) begin
          map_wdata = rd_data & ~hit.range;
          map_we    = !hit.found;
          rsp_d     = hit.found ? '{status: iba_pkg::ST_NOTUSED, id_out: '0}
                                : '{status: iba_pkg::ST_OK, id_out: id_q};
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (op_q == iba_pkg::ACT_CLAIM) begin
          map_we  = hit.found;
          rsp_d   = hit.found ? '{status: iba_pkg::ST_OK, id_out: id_q}
                              : '{status: iba_pkg::ST_BUSY, id_out: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (hit.found) begin
          map_we  = 1'b1;
          rsp_d   = '{status: iba_pkg::ST_OK, id_out: {word_q, hit.pos}};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (word_q == last_q) begin
          rsp_d   = '{status: iba_pkg::ST_NOFREE, id_out: '0};
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          word_d = word_q + iba_pkg::WORD_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      op_q    <= iba_pkg::ACT_ALLOC;
      word_q  <= '0;
      last_q  <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      id_q    <= '0;
      rsp_q   <= '{status: iba_pkg::ST_OK, id_out: '0};
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      op_q    <= op_d;
      word_q  <= word_d;
      last_q  <= last_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      id_q    <= id_d;
      rsp_q   <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // A result beat follows only an accepted request or a cycle of scanning.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept) || $past(state_q == S_SCAN))
    else $error("result beat without a request");

  // A failed request never reports an ID.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != iba_pkg::ST_OK |-> rsp_o.id_out == '0)
    else $error("failed request reports an ID");

  // The scan pointer never runs past the last word of the range.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> word_q <= last_q)
    else $error("scan ran past the range");

  // The IDs below the first valid ID stay taken.
  a_low_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q == '0 |-> (rd_data & iba_pkg::RESET_WORD0) == iba_pkg::RESET_WORD0)
    else $error("reserved low ID was freed");
`endif

endmodule
`default_nettype wire

// ===== dv/id_grant_checker.sv =====
// Checker for the ID allocator: predicts each request's result and compares the result beats.
module id_grant_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire iba_pkg::req_t             req_i,
  input  wire logic                      done_i,
  input  wire iba_pkg::rsp_t             rsp_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [iba_pkg::CFG_W-1:0] cfg_data_i,
  output int                             mismatch_count_o,
  output int                             pending_count_o,
  output int                             results_checked_o,
  output int                             granted_count_o,
  output int                             exhausted_count_o
);

  logic [iba_pkg::WORD_BITS-1:0] taken_map [iba_pkg::MAP_WORDS];
  logic [iba_pkg::CFG_W-1:0]     reserved_q;
  logic [iba_pkg::CFG_W-1:0]     ids_q;
  iba_pkg::rsp_t                 expected_grants [$];

  function automatic bit is_taken(input int id);
    return taken_map[id / iba_pkg::WORD_BITS][id % iba_pkg::WORD_BITS];
  endfunction

  function automatic void mark(input int id, input bit val);
    taken_map[id / iba_pkg::WORD_BITS][id % iba_pkg::WORD_BITS] = val;
  endfunction

  // Applies one request to the local map and returns the result it must produce.
  function automatic iba_pkg::rsp_t predict_grant(input iba_pkg::req_t r);
    iba_pkg::rsp_t g;
    int   n;
    int   lo;
    int   hi;
    int   k;
    int   id;
    n  = (int'(ids_q) < iba_pkg::CAPACITY) ? int'(ids_q) : iba_pkg::CAPACITY;
    id = int'(r.id_in);
    g.status = iba_pkg::ST_INVALID;
    g.id_out = '0;
    case (r.action)
      iba_pkg::ACT_ALLOC: begin
        lo = r.system_range ? iba_pkg::FIRST_VALID_ID : int'(reserved_q);
        hi = r.system_range ? int'(reserved_q) : n;
        g.status = iba_pkg::ST_NOFREE;
        // A range that ends beyond the managed count is refused as a whole.
        if (hi <= n) begin
          for (k = lo; k < hi && g.status != iba_pkg::ST_OK; k++) begin
            if (!is_taken(k)) begin
              mark(k, 1'b1);
              g.status = iba_pkg::ST_OK;
              g.id_out = iba_pkg::ID_W'(k);
            end
          end
        end
      end
      iba_pkg::ACT_CLAIM: begin
        if ((r.system_range && id >= int'(reserved_q)) || id >= n) begin
          g.status = iba_pkg::ST_INVALID;
        end else if (is_taken(id)) begin
          g.status = iba_pkg::ST_BUSY;
        end else begin
          mark(id, 1'b1);
          g.status = iba_pkg::ST_OK;
          g.id_out = r.id_in;
        end
      end
      iba_pkg::ACT_RELEASE: begin
        if (id >= n || id < iba_pkg::FIRST_VALID_ID) begin
          g.status = iba_pkg::ST_INVALID;
        end else if (!is_taken(id)) begin
          g.status = iba_pkg::ST_NOTUSED;
        end else begin
          mark(id, 1'b0);
          g.status = iba_pkg::ST_OK;
          g.id_out = r.id_in;
        end
      end
      default: begin
        g.status = iba_pkg::ST_INVALID;
      end
    endcase
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iba_pkg::rsp_t want;
    if (!rst_ni) begin
      for (int w = 0; w < iba_pkg::MAP_WORDS; w++) begin
        taken_map[w] = '0;
      end
      taken_map[0]      = iba_pkg::RESET_WORD0;
      reserved_q        = '0;
      ids_q             = iba_pkg::CFG_W'(1024);
      expected_grants.delete();
      mismatch_count_o  = 0;
      results_checked_o = 0;
      granted_count_o   = 0;
      exhausted_count_o = 0;
    end else begin
      // The result beat of the previous request can share an edge with the next request.
      if (done_i === 1'b1) begin
        results_checked_o++;
        if (expected_grants.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10) begin
            $display("%m: result beat with nothing outstanding: status %0d id %0d",
                     rsp_i.status, rsp_i.id_out);
          end
        end else begin
          want = expected_grants.pop_front();
          if (want.status == iba_pkg::ST_OK) granted_count_o++;
          if (want.status == iba_pkg::ST_NOFREE) exhausted_count_o++;
          if (rsp_i.status !== want.status || rsp_i.id_out !== want.id_out) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%m: mismatch: expected status %0d id %0d, got status %0d id %0d",
                       want.status, want.id_out, rsp_i.status, rsp_i.id_out);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        expected_grants.push_back(predict_grant(req_i));
      end
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == iba_pkg::CFG_RESERVED) begin
          reserved_q = cfg_data_i;
        end else begin
          ids_q = cfg_data_i;
        end
      end
    end
    pending_count_o = expected_grants.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top of the ID allocator: clock, reset, request stimulus and the verdict.
module tb_top;

  localparam logic [1:0] ACT_UNKNOWN    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_ITEMS    = 120;
  localparam int         NUM_PHASES     = 7;

  logic                      clk_i;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  iba_pkg::req_t             req;
  logic                      done;
  iba_pkg::rsp_t             rsp;
  logic                      cfg_we;
  logic                      cfg_idx;
  logic [iba_pkg::CFG_W-1:0] cfg_data;

  int mismatch_count;
  int pending_count;
  int results_checked;
  int granted_count;
  int exhausted_count;
  int idle_cycles;
  int burst_left;
  int cur_reserved;
  int cur_ids;

  id_bitmap_allocator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  id_grant_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .start             (start),
    .busy              (busy),
    .req_i             (req),
    .done_i            (done),
    .rsp_i             (rsp),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count),
    .results_checked_o (results_checked),
    .granted_count_o   (granted_count),
    .exhausted_count_o (exhausted_count)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Any accepted request, result beat or register write counts as progress.
  always @(posedge clk_i) begin
    if (!rst_n || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic iba_pkg::req_t mk_req(input logic [1:0] act, input logic sys,
                                           input int id);
    iba_pkg::req_t r;
    r.action       = act;
    r.system_range = sys;
    r.id_in        = iba_pkg::ID_W'(id);
    return r;
  endfunction

  // Holds the beat until it is taken, then either stays in the burst or pauses.
  task automatic drive_item(input iba_pkg::req_t r);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic wait_idle();
    if (start) start <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending_count != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int resv, input int ids);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= iba_pkg::CFG_RESERVED;
    cfg_data <= iba_pkg::CFG_W'(resv);
    @(posedge clk_i);
    cfg_idx  <= iba_pkg::CFG_IDS;
    cfg_data <= iba_pkg::CFG_W'(ids);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_reserved = resv;
    cur_ids      = ids;
  endtask

  // Mostly allocate/release traffic, much of it aimed where IDs are actually handed out,
  // so ranges fill up, drain and refill; some lands on the range edges, the rest anywhere.
  function automatic iba_pkg::req_t random_req();
    logic [1:0] act;
    logic       sys;
    int         roll;
    int         n;
    int         id;
    roll = $urandom_range(0, 99);
    act  = (roll < 40) ? iba_pkg::ACT_ALLOC : (roll < 65) ? iba_pkg::ACT_CLAIM :
           (roll < 95) ? iba_pkg::ACT_RELEASE : ACT_UNKNOWN;
    sys  = 1'($urandom_range(0, 1));
    n    = (cur_ids < iba_pkg::CAPACITY) ? cur_ids : iba_pkg::CAPACITY;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: id = (sys ? iba_pkg::FIRST_VALID_ID : cur_reserved) + $urandom_range(0, 40);
      4:          id = cur_reserved + $urandom_range(0, 6) - 3;
      5:          id = n + $urandom_range(0, 6) - 3;
      6:          id = $urandom_range(0, 3);
      default:    id = $urandom_range(0, 1023);
    endcase
    if (id < 0) id = 0;
    if (id > 1023) id = 1023;
    return mk_req(act, sys, id);
  endfunction

  initial begin
    int phase_reserved [NUM_PHASES];
    int phase_ids [NUM_PHASES];
    phase_reserved = '{16, 1, 0, 1024, 200, 70, 40};
    phase_ids      = '{64, 8, 1, 1024, 2047, 130, 20};
    rst_n        <= 1'b0;
    start        <= 1'b0;
    req          <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= iba_pkg::CFG_RESERVED;
    cfg_data     <= '0;
    burst_left   = 0;
    cur_reserved = 0;
    cur_ids      = 1024;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;

    // Default limits: empty system range, whole map as user range.
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b0, 1023));
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b1, 0));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 0));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b1, 5));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 1023));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 1023));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 1023));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 1023));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b1, 0));
    drive_item(mk_req(ACT_UNKNOWN, 1'b1, 1023));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 63));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 64));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 64));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 1));

    // System range reaching past the managed count, user range empty.
    set_limits(1024, 100);
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b1, 0));
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b0, 0));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 100));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 99));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 512));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b1, 98));

    // A single managed ID, which is the permanently taken one.
    set_limits(2, 1);
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b1, 0));
    drive_item(mk_req(iba_pkg::ACT_ALLOC, 1'b0, 0));
    drive_item(mk_req(iba_pkg::ACT_CLAIM, 1'b0, 0));
    drive_item(mk_req(iba_pkg::ACT_RELEASE, 1'b0, 0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limits(phase_reserved[p], phase_ids[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        drive_item(random_req());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    $display("Checked %0d result beats over %0d limit settings, including both range extremes.",
             results_checked, NUM_PHASES + 3);
    $display("%0d requests succeeded and %0d allocations found their range exhausted.",
             granted_count, exhausted_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
